// ----- sv/cov3_pkg.sv -----
// ---------------------------------------------------------------------------
// cov3_pkg
// Shared widths, defaults and the set snapshot type of the covariance block.
// ---------------------------------------------------------------------------
package cov3_pkg;

	localparam int COORD_W          = 16;
	localparam int CNT_W            = 17;
	localparam int SUM_W            = 33;
	localparam int PROD_W           = 48;
	localparam int MAX_VERTICES_DEF = 65536;
	localparam int COORD_BITS_DEF   = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam int NUM_W   = 64;
	localparam int DEN_W   = 33;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int RES_W   = 32;
	localparam int VAR_W   = 31;

	// accumulated sums of one finished set
	typedef struct packed {
		logic [CNT_W-1:0]         n;
		logic signed [SUM_W-1:0]  sx;
		logic signed [SUM_W-1:0]  sy;
		logic signed [SUM_W-1:0]  sz;
		logic signed [PROD_W-1:0] sxx;
		logic signed [PROD_W-1:0] syy;
		logic signed [PROD_W-1:0] szz;
		logic signed [PROD_W-1:0] sxy;
		logic signed [PROD_W-1:0] sxz;
		logic signed [PROD_W-1:0] syz;
		logic                     ovf;
	} snap_t;

endpackage

// ----- sv/cov3_if.sv -----
// ---------------------------------------------------------------------------
// cov3 channel interfaces
// Vertex input channel and covariance result channel, valid/ready.
// ---------------------------------------------------------------------------
interface cov3_vtx_if;
	logic        valid;
	logic        ready;
	logic [15:0] coord_x;
	logic [15:0] coord_y;
	logic [15:0] coord_z;
	logic        last_vertex;

	modport source(output valid, output coord_x, output coord_y, output coord_z,
		output last_vertex, input ready);
	modport sink(input valid, input coord_x, input coord_y, input coord_z,
		input last_vertex, output ready);
endinterface

interface cov3_res_if;
	logic        valid;
	logic        ready;
	logic [30:0] var_xx;
	logic [30:0] var_yy;
	logic [30:0] var_zz;
	logic [31:0] cov_xy;
	logic [31:0] cov_xz;
	logic [31:0] cov_yz;
	logic [16:0] vertex_count;
	logic        too_many;

	modport source(output valid, output var_xx, output var_yy, output var_zz,
		output cov_xy, output cov_xz, output cov_yz, output vertex_count,
		output too_many, input ready);
	modport sink(input valid, input var_xx, input var_yy, input var_zz,
		input cov_xy, input cov_xz, input cov_yz, input vertex_count,
		input too_many, output ready);
endinterface

// ----- sv/cov3_front.sv -----
// ---------------------------------------------------------------------------
// cov3_front
// Takes one vertex per cycle while ready is high, squares and cross products
// in a two stage pipe and accumulates; a marked vertex queues the set.
// ---------------------------------------------------------------------------
module cov3_front #(
	parameter int MAX_VERTICES = cov3_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = cov3_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	cov3_vtx_if.sink                    vtx,
	input  logic [cov3_pkg::QCNT_W-1:0] q_count,
	output logic                        push,
	output cov3_pkg::snap_t             push_data
);

	localparam int SHIFT = cov3_pkg::COORD_W - COORD_BITS;
	localparam int PW    = 2 * cov3_pkg::COORD_W;

	logic signed [cov3_pkg::COORD_W-1:0] x_in, y_in, z_in;
	logic signed [cov3_pkg::COORD_W-1:0] x_s1, y_s1, z_s1;
	logic                                last_s1, valid_s1;
	logic signed [cov3_pkg::COORD_W-1:0] x_s2, y_s2, z_s2;
	logic signed [PW-1:0]                pxx_s2, pyy_s2, pzz_s2, pxy_s2, pxz_s2, pyz_s2;
	logic                                last_s2, valid_s2;

	logic [cov3_pkg::CNT_W-1:0]          count_q, count_nxt;
	logic signed [cov3_pkg::SUM_W-1:0]   sx_q, sy_q, sz_q, sx_nxt, sy_nxt, sz_nxt;
	logic signed [cov3_pkg::PROD_W-1:0]  sxx_q, syy_q, szz_q, sxy_q, sxz_q, syz_q;
	logic signed [cov3_pkg::PROD_W-1:0]  sxx_nxt, syy_nxt, szz_nxt;
	logic signed [cov3_pkg::PROD_W-1:0]  sxy_nxt, sxz_nxt, syz_nxt;
	logic                                ovf_q, ovf_nxt, full;
	logic [cov3_pkg::QCNT_W:0]           pending;
	logic                                accept;

	// only the low COORD_BITS bits count, sign-extended
	assign x_in = ($signed(vtx.coord_x) <<< SHIFT) >>> SHIFT;
	assign y_in = ($signed(vtx.coord_y) <<< SHIFT) >>> SHIFT;
	assign z_in = ($signed(vtx.coord_z) <<< SHIFT) >>> SHIFT;

	// never let in more set ends than the queue can still hold
	assign pending = {1'b0, q_count}
		+ (cov3_pkg::QCNT_W+1)'(valid_s1 && last_s1)
		+ (cov3_pkg::QCNT_W+1)'(valid_s2 && last_s2);
	assign vtx.ready = pending < (cov3_pkg::QCNT_W+1)'(cov3_pkg::QUEUE_DEPTH);
	assign accept    = vtx.valid && vtx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_in;
		y_s1    <= y_in;
		z_s1    <= z_in;
		last_s1 <= vtx.last_vertex;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		z_s2    <= z_s1;
		last_s2 <= last_s1;
		pxx_s2  <= x_s1 * x_s1;
		pyy_s2  <= y_s1 * y_s1;
		pzz_s2  <= z_s1 * z_s1;
		pxy_s2  <= x_s1 * y_s1;
		pxz_s2  <= x_s1 * z_s1;
		pyz_s2  <= y_s1 * z_s1;
	end

	assign full = count_q >= cov3_pkg::CNT_W'(MAX_VERTICES);

	always_comb begin
		count_nxt = count_q;
		sx_nxt    = sx_q;
		sy_nxt    = sy_q;
		sz_nxt    = sz_q;
		sxx_nxt   = sxx_q;
		syy_nxt   = syy_q;
		szz_nxt   = szz_q;
		sxy_nxt   = sxy_q;
		sxz_nxt   = sxz_q;
		syz_nxt   = syz_q;
		ovf_nxt   = ovf_q;
		if (full) begin
			ovf_nxt = 1'b1;
		end else begin
			count_nxt = count_q + 1'b1;
			sx_nxt    = sx_q + cov3_pkg::SUM_W'(x_s2);
			sy_nxt    = sy_q + cov3_pkg::SUM_W'(y_s2);
			sz_nxt    = sz_q + cov3_pkg::SUM_W'(z_s2);
			sxx_nxt   = sxx_q + cov3_pkg::PROD_W'(pxx_s2);
			syy_nxt   = syy_q + cov3_pkg::PROD_W'(pyy_s2);
			szz_nxt   = szz_q + cov3_pkg::PROD_W'(pzz_s2);
			sxy_nxt   = sxy_q + cov3_pkg::PROD_W'(pxy_s2);
			sxz_nxt   = sxz_q + cov3_pkg::PROD_W'(pxz_s2);
			syz_nxt   = syz_q + cov3_pkg::PROD_W'(pyz_s2);
		end
	end

	assign push = valid_s2 && last_s2;
	always_comb begin
		push_data.n   = count_nxt;
		push_data.sx  = sx_nxt;
		push_data.sy  = sy_nxt;
		push_data.sz  = sz_nxt;
		push_data.sxx = sxx_nxt;
		push_data.syy = syy_nxt;
		push_data.szz = szz_nxt;
		push_data.sxy = sxy_nxt;
		push_data.sxz = sxz_nxt;
		push_data.syz = syz_nxt;
		push_data.ovf = ovf_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sz_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			szz_q   <= '0;
			sxy_q   <= '0;
			sxz_q   <= '0;
			syz_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (valid_s2) begin
			if (last_s2) begin
				count_q <= '0;
				sx_q    <= '0;
				sy_q    <= '0;
				sz_q    <= '0;
				sxx_q   <= '0;
				syy_q   <= '0;
				szz_q   <= '0;
				sxy_q   <= '0;
				sxz_q   <= '0;
				syz_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_nxt;
				sx_q    <= sx_nxt;
				sy_q    <= sy_nxt;
				sz_q    <= sz_nxt;
				sxx_q   <= sxx_nxt;
				syy_q   <= syy_nxt;
				szz_q   <= szz_nxt;
				sxy_q   <= sxy_nxt;
				sxz_q   <= sxz_nxt;
				syz_q   <= syz_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

endmodule

// ----- sv/cov3_queue.sv -----
// ---------------------------------------------------------------------------
// cov3_queue
// Small first-in first-out queue of finished set snapshots.
// ---------------------------------------------------------------------------
module cov3_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  cov3_pkg::snap_t             push_data,
	input  logic                        pop,
	output cov3_pkg::snap_t             pop_data,
	output logic                        empty,
	output logic [cov3_pkg::QCNT_W-1:0] count
);

	cov3_pkg::snap_t                 mem_q [cov3_pkg::QUEUE_DEPTH];
	logic [cov3_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [cov3_pkg::QCNT_W-1:0]     cnt_q;

	assign pop_data = mem_q[rd_ptr_q];
	assign empty    = cnt_q == '0;
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + cov3_pkg::QCNT_W'(push) - cov3_pkg::QCNT_W'(pop);
		end
	end

endmodule

// ----- sv/cov3_back.sv -----
// ---------------------------------------------------------------------------
// cov3_back
// Works out the six covariance entries of one set with a shared multiplier
// and a bit-serial divider, then holds the result in an output register.
// ---------------------------------------------------------------------------
module cov3_back (
	input  logic            clk,
	input  logic            arst_n,
	input  cov3_pkg::snap_t pop_data,
	input  logic            empty,
	output logic            pop,
	cov3_res_if.source      res
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_PREP, ST_DIV, ST_FIN, ST_OUT
	} state_t;

	// partial products: n*n, n*sab low/high, sa*sb low/high
	typedef enum logic [2:0] {
		STEP_DEN, STEP_NLO, STEP_NHI, STEP_PLO, STEP_PHI
	} step_t;

	localparam logic [2:0] LAST_ENT = 3'd5;

	state_t                              state_q;
	step_t                               step_q;
	logic [2:0]                          ent_q;
	cov3_pkg::snap_t                     snap_q;
	logic signed [cov3_pkg::SUM_W-1:0]   sa, sb;
	logic signed [cov3_pkg::PROD_W-1:0]  sab;
	logic signed [cov3_pkg::MUL_A_W-1:0] mul_a;
	logic signed [cov3_pkg::MUL_B_W-1:0] mul_b;
	logic signed [cov3_pkg::MUL_P_W-1:0] p_q;
	logic signed [cov3_pkg::NUM_W-1:0]   p64, num_q, mag;
	logic [cov3_pkg::DEN_W-1:0]          den_q, rem_q;
	logic [cov3_pkg::DEN_W:0]            trial;
	logic                                ge;
	logic [cov3_pkg::RES_W-1:0]          dvd_q;
	logic [4:0]                          bit_q;
	logic                                neg_q;
	logic [cov3_pkg::RES_W-1:0]          res_q [6];
	logic                                out_valid_q;

	always_comb begin
		case (ent_q)
			3'd0: begin sab = snap_q.sxx; sa = snap_q.sx; sb = snap_q.sx; end
			3'd1: begin sab = snap_q.syy; sa = snap_q.sy; sb = snap_q.sy; end
			3'd2: begin sab = snap_q.szz; sa = snap_q.sz; sb = snap_q.sz; end
			3'd3: begin sab = snap_q.sxy; sa = snap_q.sx; sb = snap_q.sy; end
			3'd4: begin sab = snap_q.sxz; sa = snap_q.sx; sb = snap_q.sz; end
			default: begin sab = snap_q.syz; sa = snap_q.sy; sb = snap_q.sz; end
		endcase
	end

	always_comb begin
		mul_a = {17'b0, snap_q.n};
		mul_b = {9'b0, snap_q.n};
		case (step_q)
			STEP_DEN: mul_b = {9'b0, snap_q.n};
			STEP_NLO: mul_b = {2'b0, sab[23:0]};
			STEP_NHI: mul_b = {{2{sab[47]}}, sab[47:24]};
			STEP_PLO: begin
				mul_a = {sa[32], sa};
				mul_b = {9'b0, sb[16:0]};
			end
			STEP_PHI: begin
				mul_a = {sa[32], sa};
				mul_b = {{10{sb[32]}}, sb[32:17]};
			end
			default: mul_b = {9'b0, snap_q.n};
		endcase
	end

	assign p64   = cov3_pkg::NUM_W'(p_q);
	assign mag   = num_q[63] ? -num_q : num_q;
	assign trial = {rem_q, dvd_q[31]};
	assign ge    = trial >= {1'b0, den_q};
	assign pop   = (state_q == ST_IDLE) && !empty;

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && !empty) begin
			snap_q <= pop_data;
		end
		if (state_q == ST_ACC) begin
			case (step_q)
				STEP_DEN: den_q <= p_q[cov3_pkg::DEN_W-1:0];
				STEP_NLO: num_q <= p64;
				STEP_NHI: num_q <= num_q + (p64 <<< 24);
				STEP_PLO: num_q <= num_q - p64;
				STEP_PHI: num_q <= num_q - (p64 <<< 17);
				default: num_q <= num_q;
			endcase
		end
		if (state_q == ST_PREP) begin
			neg_q <= num_q[63];
			rem_q <= {1'b0, mag[63:32]};
			dvd_q <= mag[31:0];
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? cov3_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[cov3_pkg::DEN_W-1:0];
			dvd_q <= {dvd_q[30:0], ge};
		end
		if (state_q == ST_FIN) begin
			res_q[ent_q] <= neg_q ? -dvd_q : dvd_q;
		end
		if (state_q == ST_OUT && (!out_valid_q || res.ready)) begin
			res.var_xx       <= res_q[0][cov3_pkg::VAR_W-1:0];
			res.var_yy       <= res_q[1][cov3_pkg::VAR_W-1:0];
			res.var_zz       <= res_q[2][cov3_pkg::VAR_W-1:0];
			res.cov_xy       <= res_q[3];
			res.cov_xz       <= res_q[4];
			res.cov_yz       <= res_q[5];
			res.vertex_count <= snap_q.n;
			res.too_many     <= snap_q.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_DEN;
			ent_q       <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						ent_q   <= '0;
						step_q  <= STEP_DEN;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					case (step_q)
						STEP_DEN: begin step_q <= STEP_NLO; state_q <= ST_MUL; end
						STEP_NLO: begin step_q <= STEP_NHI; state_q <= ST_MUL; end
						STEP_NHI: begin step_q <= STEP_PLO; state_q <= ST_MUL; end
						STEP_PLO: begin step_q <= STEP_PHI; state_q <= ST_MUL; end
						default: state_q <= ST_PREP;
					endcase
				end
				ST_PREP: begin
					bit_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == 5'd31) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (ent_q == LAST_ENT) begin
						state_q <= ST_OUT;
					end else begin
						ent_q   <= ent_q + 1'b1;
						step_q  <= STEP_NLO;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || res.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid = out_valid_q;

endmodule

// ----- sv/covariance_3d_accumulator.sv -----
// ---------------------------------------------------------------------------
// covariance_3d_accumulator
// Streaming 3x3 population covariance of vertex sets.
// ---------------------------------------------------------------------------
// Vertices are taken one per cycle while the queue has room and accumulated
// through a two stage multiply pipe; the beat marked last closes the set and
// queues its sums (up to four sets wait). Each set's six entries are then
// computed one after the other by one shared 34x26 multiplier and a
// one-bit-per-cycle divider, so short sets run at the divider's pace once the
// queue is full, and the result waits in an output register.
module covariance_3d_accumulator #(
	parameter int MAX_VERTICES = cov3_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = cov3_pkg::COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cov3_vtx_if.sink   vtx,
	cov3_res_if.source res
);

	logic                        push, pop, empty;
	cov3_pkg::snap_t             push_data, pop_data;
	logic [cov3_pkg::QCNT_W-1:0] q_count;

	cov3_front #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vtx      (vtx),
		.q_count  (q_count),
		.push     (push),
		.push_data(push_data)
	);

	cov3_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty),
		.count    (q_count)
	);

	cov3_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop_data(pop_data),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

endmodule
